// ----- rtl/pal_pkg.sv -----
// shared constants, operation codes and control/status structs for the positional array list
// used by pal_ctrl, pal_dpath and positional_array_list; no dependencies
package pal_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int KEY_W         = 32;
    localparam int POS_W         = 5;
    localparam int ADDR_W        = 4;
    localparam int CNT_W         = 5;
    localparam int FUNC_W        = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic walk;
        logic finish;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              err;
        logic [FUNC_W-1:0] op;
        logic              walk_done;
    } stat_t;

endpackage

// ----- rtl/pal_ctrl.sv -----
// controller state machine for the positional array list
// depends on pal_pkg for the command and status structs and operation codes
module pal_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pal_pkg::stat_t stat,
    output pal_pkg::cmd_t  cmd,
    output logic           busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_FINISH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.err)
                    state_next = S_DONE;
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    if (stat.op == pal_pkg::FUNC_SEARCH)
                        state_next = S_DONE;
                    else
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/pal_dpath.sv -----
// datapath of the positional array list: entry memories, walk pointer, count and result registers
// depends on pal_pkg for widths, operation codes and the command and status structs
module pal_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pal_pkg::cmd_t                     cmd,
    output pal_pkg::stat_t                    stat,
    input  logic [pal_pkg::FUNC_W-1:0]        func,
    input  logic [pal_pkg::POS_W-1:0]         position,
    input  logic signed [pal_pkg::KEY_W-1:0]  entry_key,
    input  logic [31:0]                       entry_payload,
    output logic                              status,
    output logic                              found,
    output logic [pal_pkg::ADDR_W-1:0]        found_position,
    output logic [pal_pkg::CNT_W-1:0]         entry_count,
    output logic                              is_empty,
    output logic                              is_full
);

    logic signed [pal_pkg::KEY_W-1:0]  key_mem [pal_pkg::CAPACITY];
    logic [pal_pkg::PAYLOAD_WIDTH-1:0] pay_mem [pal_pkg::CAPACITY];

    logic [pal_pkg::FUNC_W-1:0]        func_reg;
    logic [pal_pkg::POS_W-1:0]         pos_reg;
    logic signed [pal_pkg::KEY_W-1:0]  key_reg;
    logic [pal_pkg::PAYLOAD_WIDTH-1:0] pay_reg;
    logic [pal_pkg::CNT_W-1:0]         count_reg;
    logic [pal_pkg::CNT_W-1:0]         ptr_reg;
    logic                              pend_reg;
    logic [pal_pkg::ADDR_W-1:0]        addr_reg;
    logic signed [pal_pkg::KEY_W-1:0]  rd_key_reg;
    logic [pal_pkg::PAYLOAD_WIDTH-1:0] rd_pay_reg;
    logic                              status_reg;
    logic                              found_reg;
    logic [pal_pkg::ADDR_W-1:0]        fpos_reg;

    logic                              is_ins;
    logic                              is_del;
    logic                              is_srch;
    logic                              err;
    logic                              more;
    logic [pal_pkg::CNT_W-1:0]         ptr_m1;
    logic [pal_pkg::ADDR_W-1:0]        rd_addr;
    logic                              rd_en;
    logic                              hit;
    logic                              wr_en;
    logic [pal_pkg::ADDR_W-1:0]        wr_addr;
    logic signed [pal_pkg::KEY_W-1:0]  wr_key;
    logic [pal_pkg::PAYLOAD_WIDTH-1:0] wr_pay;
    logic [pal_pkg::CNT_W-1:0]         ptr_init;

    assign is_ins  = (func_reg == pal_pkg::FUNC_INSERT);
    assign is_del  = (func_reg == pal_pkg::FUNC_DELETE);
    assign is_srch = (func_reg == pal_pkg::FUNC_SEARCH);

    always_comb
    begin
        case (func_reg)
            pal_pkg::FUNC_INSERT:
                err = (count_reg == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) || (pos_reg > count_reg);
            pal_pkg::FUNC_DELETE:
                err = (count_reg == '0) || (pos_reg >= count_reg);
            pal_pkg::FUNC_SEARCH:
                err = 1'b0;
            default:
                err = 1'b1;
        endcase
    end

    // insert walks down from the top reading ptr-1, delete and search walk up reading ptr
    assign ptr_m1  = ptr_reg - 1'b1;
    assign more    = is_ins ? (ptr_reg > pos_reg) : (ptr_reg < count_reg);
    assign rd_addr = is_ins ? ptr_m1[pal_pkg::ADDR_W-1:0] : ptr_reg[pal_pkg::ADDR_W-1:0];
    assign rd_en   = cmd.walk && more;
    assign hit     = pend_reg && is_srch && (rd_key_reg == key_reg);

    always_comb
    begin
        case (func_reg)
            pal_pkg::FUNC_INSERT: ptr_init = count_reg;
            pal_pkg::FUNC_DELETE: ptr_init = pos_reg + 1'b1;
            default:              ptr_init = '0;
        endcase
    end

    // pending beat from last cycle's read lands one slot over; finish drops in the new entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_key  = rd_key_reg;
        wr_pay  = rd_pay_reg;
        if (cmd.finish && is_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[pal_pkg::ADDR_W-1:0];
            wr_key  = key_reg;
            wr_pay  = pay_reg;
        end
        else if (cmd.walk && pend_reg && is_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg + 1'b1;
        end
        else if (cmd.walk && pend_reg && is_del)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pos_reg  <= position;
            key_reg  <= entry_key;
            pay_reg  <= entry_payload[pal_pkg::PAYLOAD_WIDTH-1:0];
        end
        if (cmd.check)
            ptr_reg <= ptr_init;
        else if (rd_en)
            ptr_reg <= is_ins ? ptr_m1 : ptr_reg + 1'b1;
        if (rd_en)
            addr_reg <= rd_addr;
        if (cmd.walk && hit && !found_reg)
            fpos_reg <= addr_reg;
        else if (cmd.load)
            fpos_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            status_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.check)
                pend_reg <= 1'b0;
            else if (cmd.walk)
                pend_reg <= more;
            if (cmd.load)
            begin
                status_reg <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.check)
                status_reg <= err;
            else if (cmd.walk && hit)
                found_reg <= 1'b1;
            if (cmd.finish && is_ins)
                count_reg <= count_reg + 1'b1;
            else if (cmd.finish && is_del)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign stat.err       = err;
    assign stat.op        = func_reg;
    assign stat.walk_done = hit || (!more && !pend_reg);

    assign status         = status_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign entry_count    = count_reg;
    assign is_empty       = (count_reg == '0);
    assign is_full        = (count_reg == pal_pkg::CNT_W'(pal_pkg::CAPACITY));

endmodule

// ----- rtl/positional_array_list.sv -----
// Ordered list of up to 16 key/payload entries with insert, delete and search by key.
// A command is taken when start is high and busy is low; busy then stays high until the
// single-cycle done strobe, which carries the result and cannot be held off, so the
// receiver must take it in that cycle. One entry moves or is compared per cycle through
// the one read port of the entry memory. After the start beat a command is checked and
// then walks the entries; an insert or delete then finishes, which updates the count and
// for an insert writes the new entry, before the done strobe. A search goes straight to
// done and stops early on a match, and a rejected command skips the walk.
// depends on pal_pkg, pal_ctrl and pal_dpath
module positional_array_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pal_pkg::FUNC_W-1:0]        func,
    input  logic [pal_pkg::POS_W-1:0]         position,
    input  logic signed [pal_pkg::KEY_W-1:0]  entry_key,
    input  logic [31:0]                       entry_payload,
    output logic                              done,
    output logic                              status,
    output logic                              found,
    output logic [pal_pkg::ADDR_W-1:0]        found_position,
    output logic [pal_pkg::CNT_W-1:0]         entry_count,
    output logic                              is_empty,
    output logic                              is_full
);

    pal_pkg::cmd_t  cmd;
    pal_pkg::stat_t stat;

    pal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pal_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .position       (position),
        .entry_key      (entry_key),
        .entry_payload  (entry_payload),
        .status         (status),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    assign done = cmd.emit;

endmodule

// ----- tb/positional_array_list_tb.sv -----
// self-checking testbench for positional_array_list: directed and random insert/delete/search
// traffic, results checked beat by beat against a shadow copy of the list
// depends on pal_pkg and the positional_array_list rtl
module positional_array_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_ITEMS   = 500;
    localparam int MAX_GAP        = 17;

    // func code 3 has no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } segment_kind_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [KEY_W-1:0]  key;
        logic [31:0]              payload;
        logic [4:0]               gap;
        logic                     drain;
    } list_cmd_t;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [ADDR_W-1:0] found_position;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
    } list_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [FUNC_W-1:0]        func = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [KEY_W-1:0]  entry_key = '0;
    logic [31:0]              entry_payload = '0;
    logic                     done;
    logic                     status;
    logic                     found;
    logic [ADDR_W-1:0]        found_position;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;

    list_cmd_t    pending_q[$];
    list_result_t outcome_q[$];

    // shadow copy of the list contents
    logic [KEY_W-1:0] shadow_key[0:CAPACITY-1];
    logic [31:0]      shadow_payload[0:CAPACITY-1];
    int               shadow_count = 0;

    // generator side: list fill level as the stimulus will leave it
    int               gen_count = 0;
    int               gap_mode = 0;
    bit               hold_for_drain = 1'b0;
    int               stim_total = 0;
    logic [31:0]      key_pool[0:7];

    int               accepted_items = 0;
    int               mismatch_cnt = 0;
    int               idle_cycles = 0;
    bit               drive_en = 1'b0;
    logic             beat_taken = 1'b0;

    list_cmd_t        cur_cmd;
    bit               presenting = 1'b0;
    bit               holding = 1'b0;
    int               gap_left = 0;

    positional_array_list u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .position       (position),
        .entry_key      (entry_key),
        .entry_payload  (entry_payload),
        .done           (done),
        .status         (status),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic list_result_t apply_list_command(input list_cmd_t c);
        list_result_t r;
        int           i;
        r = '0;
        case (c.func)
            FUNC_INSERT:
            begin
                if (shadow_count >= CAPACITY || int'(c.position) > shadow_count)
                    r.status = 1'b1;
                else
                begin
                    for (i = shadow_count; i > int'(c.position); i--)
                    begin
                        shadow_key[i]     = shadow_key[i-1];
                        shadow_payload[i] = shadow_payload[i-1];
                    end
                    shadow_key[c.position]     = c.key;
                    shadow_payload[c.position] = c.payload;
                    shadow_count++;
                end
            end
            FUNC_DELETE:
            begin
                if (shadow_count == 0 || int'(c.position) >= shadow_count)
                    r.status = 1'b1;
                else
                begin
                    for (i = int'(c.position); i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i]     = shadow_key[i+1];
                        shadow_payload[i] = shadow_payload[i+1];
                    end
                    shadow_count--;
                end
            end
            FUNC_SEARCH:
            begin
                // lowest matching position wins, all 32 key bits compared
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!r.found && shadow_key[i] == c.key)
                    begin
                        r.found          = 1'b1;
                        r.found_position = ADDR_W'(i);
                    end
                end
            end
            default:
                r.status = 1'b1;
        endcase
        r.entry_count = CNT_W'(shadow_count);
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count == CAPACITY);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic add_cmd(input logic [FUNC_W-1:0] f, input int p,
                           input logic [31:0] k, input logic [31:0] pl);
        list_cmd_t c;
        c.func     = f;
        c.position = POS_W'(p);
        c.key      = k;
        c.payload  = pl;
        c.drain    = hold_for_drain;
        case (gap_mode)
            0:       c.gap = '0;
            1:       c.gap = 5'($urandom_range(0, MAX_GAP));
            default: c.gap = 5'($urandom_range(0, 3));
        endcase
        hold_for_drain = 1'b0;
        pending_q.push_back(c);
        stim_total++;
        if (f == FUNC_INSERT && gen_count < CAPACITY && p <= gen_count)
            gen_count++;
        else if (f == FUNC_DELETE && gen_count > 0 && p < gen_count)
            gen_count--;
    endtask

    function automatic int pick_pos(input bit for_insert);
        int top;
        top = for_insert ? gen_count : gen_count - 1;
        if (top < 0 || $urandom_range(0, 99) < 15)
            return $urandom_range(0, 31);
        return $urandom_range(0, top);
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 1) == 0)
            return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_random_op();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            add_cmd(FUNC_INSERT, pick_pos(1'b1), pick_key(), pick_payload());
        else if (pick < 14)
            add_cmd(FUNC_DELETE, pick_pos(1'b0), pick_key(), pick_payload());
        else if (pick < 19)
            add_cmd(FUNC_SEARCH, $urandom_range(0, 31), pick_key(), pick_payload());
        else
            add_cmd(FUNC_UNUSED, $urandom_range(0, 31), pick_key(), pick_payload());
    endtask

    // driver: one command beat at a time, idles per item, may hold until all results are in
    always @(negedge clk)
    begin
        if (drive_en)
        begin
            if (start && beat_taken)
                presenting = 1'b0;
            if (!presenting && (holding || pending_q.size() != 0))
            begin
                if (!holding)
                begin
                    cur_cmd  = pending_q.pop_front();
                    gap_left = cur_cmd.gap;
                    holding  = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else if (!cur_cmd.drain || outcome_q.size() == 0)
                begin
                    holding    = 1'b0;
                    presenting = 1'b1;
                end
            end
            start <= presenting;
            if (presenting)
            begin
                func          <= cur_cmd.func;
                position      <= cur_cmd.position;
                entry_key     <= cur_cmd.key;
                entry_payload <= cur_cmd.payload;
            end
        end
    end

    // monitor: result beats checked first, then a command beat adds its prediction
    always @(posedge clk)
    begin : monitor
        list_cmd_t    seen;
        list_result_t want;
        bit           activity;
        if (rst_n)
        begin
            activity = 1'b0;
            if (done)
            begin
                activity = 1'b1;
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    mismatch_cnt++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("found", want.found, found);
                    check_field("found_position", want.found_position, found_position);
                    check_field("entry_count", want.entry_count, entry_count);
                    check_field("is_empty", want.is_empty, is_empty);
                    check_field("is_full", want.is_full, is_full);
                end
            end
            if (start && !busy)
            begin
                activity      = 1'b1;
                seen          = '0;
                seen.func     = func;
                seen.position = position;
                seen.key      = entry_key;
                seen.payload  = entry_payload;
                outcome_q.push_back(apply_list_command(seen));
                accepted_items++;
            end
            beat_taken <= start && !busy;
            idle_cycles = activity ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        segment_kind_t seg;
        int            seg_len;
        int            n;
        bit            first_seg;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (n = 5; n < 8; n++)
            key_pool[n] = $urandom();

        // directed: empty list corners, extreme keys and payloads, bad positions
        gap_mode = 1;
        add_cmd(FUNC_SEARCH, 0, 32'h0000_0000, 32'h0);
        add_cmd(FUNC_DELETE, 0, 32'h0, 32'h0);
        add_cmd(FUNC_INSERT, 1, 32'h1, 32'h1);
        add_cmd(FUNC_UNUSED, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(FUNC_INSERT, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        add_cmd(FUNC_INSERT, 1, 32'h7FFF_FFFF, 32'h0000_0000);
        add_cmd(FUNC_INSERT, 0, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        add_cmd(FUNC_INSERT, 3, 32'h0000_0000, 32'h5A5A_5A5A);
        add_cmd(FUNC_INSERT, 2, 32'h7FFF_FFFF, 32'h0000_0001);
        add_cmd(FUNC_SEARCH, 31, 32'h7FFF_FFFF, 32'h0);
        add_cmd(FUNC_SEARCH, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        add_cmd(FUNC_SEARCH, 16, 32'h1234_5678, 32'h0);
        add_cmd(FUNC_SEARCH, 0, 32'hFFFF_FFFF, 32'h0);
        add_cmd(FUNC_INSERT, 6, 32'h2, 32'h2);
        add_cmd(FUNC_DELETE, 5, 32'h0, 32'h0);
        add_cmd(FUNC_DELETE, 31, 32'h0, 32'h0);
        add_cmd(FUNC_DELETE, 2, 32'h0, 32'h0);
        add_cmd(FUNC_DELETE, 0, 32'h0, 32'h0);
        add_cmd(FUNC_DELETE, 2, 32'h0, 32'h0);
        add_cmd(FUNC_SEARCH, 0, 32'h0000_0000, 32'h0);

        // random: fill to full, empty again, then randomly chosen fill, drain and mixed segments
        first_seg = 1'b1;
        seg = SEG_FILL;
        while (stim_total < RANDOM_ITEMS + 20)
        begin
            gap_mode       = $urandom_range(0, 2);
            hold_for_drain = first_seg || ($urandom_range(0, 2) == 0);
            case (seg)
                SEG_FILL:
                begin
                    while (gen_count < CAPACITY)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            add_cmd(FUNC_SEARCH, $urandom_range(0, 31), pick_key(),
                                    pick_payload());
                        else
                            add_cmd(FUNC_INSERT, pick_pos(1'b1), pick_key(), pick_payload());
                    end
                    add_cmd(FUNC_INSERT, $urandom_range(0, 31), pick_key(), pick_payload());
                    add_cmd(FUNC_SEARCH, 0, pick_key(), pick_payload());
                end
                SEG_DRAIN:
                begin
                    while (gen_count > 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            add_cmd(FUNC_SEARCH, $urandom_range(0, 31), pick_key(),
                                    pick_payload());
                        else
                            add_cmd(FUNC_DELETE, pick_pos(1'b0), pick_key(), pick_payload());
                    end
                    add_cmd(FUNC_DELETE, $urandom_range(0, 31), pick_key(), pick_payload());
                end
                default:
                begin
                    seg_len = $urandom_range(20, 60);
                    for (n = 0; n < seg_len; n++)
                        add_random_op();
                end
            endcase
            if (first_seg)
                seg = SEG_DRAIN;
            else
                seg = segment_kind_t'($urandom_range(0, 2));
            first_seg = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk) drive_en = 1'b1;

        while (accepted_items < stim_total)
            @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- positional_array_list.f -----
rtl/pal_pkg.sv
rtl/pal_ctrl.sv
rtl/pal_dpath.sv
rtl/positional_array_list.sv
tb/positional_array_list_tb.sv
